>>> design/pktg_pkg.sv
// Package for the piano key sine tone generator: widths, register codes,
// controller types and the constant frequency and quarter-wave sine tables.
// No dependencies.
`default_nettype none

package pktg_pkg;

    localparam int PHASE_BITS   = 24;
    localparam int SINE_ENTRIES = 1024;
    localparam int KEY_COUNT    = 88;

    localparam int KEY_BITS     = 7;
    localparam int SAMPLE_BITS  = 8;
    localparam int RATE_BITS    = 18;
    localparam int FREQ_BITS    = 21;
    localparam int STEP_SHIFT   = PHASE_BITS - 6;
    localparam int DIV_BITS     = FREQ_BITS + STEP_SHIFT;
    localparam int DIV_CNT_BITS = $clog2(DIV_BITS);
    localparam int IDX_BITS     = $clog2(SINE_ENTRIES);
    localparam int QTR_BITS     = IDX_BITS - 2;
    localparam int SINE_QTR     = SINE_ENTRIES / 4;
    localparam int MAG_BITS     = 8;
    localparam int ROM_BITS     = MAG_BITS + 1;
    localparam int ADDR_BITS    = 3;
    localparam int DATA_BITS    = 32;

    localparam logic [RATE_BITS-1:0]   RATE_RESET  = RATE_BITS'(8000);
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MID  = SAMPLE_BITS'(128);
    localparam logic [63:0]            HALF_PI_Q30 = 64'd1686629713;

    localparam logic REG_SAMPLE_RATE = 1'b0;

    localparam logic [31:0] SEMITONE_Q16 [12] = '{
        32'd28835840, 32'd30550508, 32'd32367136, 32'd34291786,
        32'd36330882, 32'd38491228, 32'd40780036, 32'd43204943,
        32'd45774043, 32'd48495909, 32'd51379626, 32'd54434817
    };

    typedef logic [KEY_COUNT-1:0][FREQ_BITS-1:0] t_freq_rom;
    typedef logic [SINE_QTR-1:0][ROM_BITS-1:0]   t_sine_rom;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_LOOKUP,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic div_init;
        logic div_step;
        logic div_last;
        logic step_clear;
        logic lookup;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic in_sounds;
        logic out_stall;
    } t_status;

    // Magnitude floor(128*sin) and a flag for a nonzero fraction, first quadrant.
    function automatic logic [ROM_BITS-1:0] sine_q_entry(input int unsigned q);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x    = (64'(q) * 64'd4 * HALF_PI_Q30) / SINE_ENTRIES;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        term = ((term * x2) >> 30) / 64'd6;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd42;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd110;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd210;
        sum  = (sum >= term) ? sum - term : 64'd0;
        return {sum[30:23], |sum[22:0]};
    endfunction

    function automatic t_sine_rom build_sine_rom();
        t_sine_rom rom;
        for (int q = 0; q < SINE_QTR; q++) begin
            rom[q] = sine_q_entry(q);
        end
        return rom;
    endfunction

    function automatic t_freq_rom build_freq_rom();
        t_freq_rom   rom;
        int          n;
        logic [63:0] b;
        rom = '0;
        for (int oct = 0; oct < 8; oct++) begin
            for (int semi = 0; semi < 12; semi++) begin
                n = oct * 12 + semi;
                if (n < KEY_COUNT) begin
                    b = 64'(SEMITONE_Q16[semi]);
                    rom[n] = FREQ_BITS'((b + (64'd1 << (11 - oct))) >> (12 - oct));
                end
            end
        end
        return rom;
    endfunction

    localparam t_sine_rom              SINE_ROM  = build_sine_rom();
    localparam logic [ROM_BITS-1:0]    SINE_PEAK = sine_q_entry(SINE_QTR);
    localparam t_freq_rom              FREQ_ROM  = build_freq_rom();

endpackage

`default_nettype wire

>>> design/pktg_ctrl.sv
// Controller state machine of the tone generator: input handshake, divider
// sequencing, table lookup and result hand-off. Depends on pktg_pkg.
`default_nettype none

module pktg_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_s_tvalid,
    input  wire                 i_note_start,
    input  pktg_pkg::t_status   i_status,
    output logic                o_s_tready,
    output pktg_pkg::t_cmd      o_cmd
);
    import pktg_pkg::*;

    t_state                  r_state;
    t_state                  n_state;
    logic [DIV_CNT_BITS-1:0] r_cnt;
    logic [DIV_CNT_BITS-1:0] n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_s_tready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    if (i_note_start && i_status.in_sounds) begin
                        o_cmd.div_init = 1'b1;
                        n_cnt          = '0;
                        n_state        = S_DIV;
                    end else begin
                        o_cmd.step_clear = i_note_start;
                        n_state          = S_LOOKUP;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == DIV_CNT_BITS'(DIV_BITS - 1)) begin
                    o_cmd.div_last = 1'b1;
                    n_state        = S_LOOKUP;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (!i_status.out_stall) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/pktg_datapath.sv
// Datapath of the tone generator: phase accumulator, phase step, bit-serial
// step divider, sine table read and output register. Depends on pktg_pkg.
`default_nettype none

module pktg_datapath (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  pktg_pkg::t_cmd                      i_cmd,
    input  wire  [pktg_pkg::KEY_BITS-1:0]       i_key,
    input  wire                                 i_note_start,
    input  wire  [pktg_pkg::RATE_BITS-1:0]      i_rate,
    input  wire                                 i_m_tready,
    output pktg_pkg::t_status                   o_status,
    output logic                                o_m_tvalid,
    output logic [pktg_pkg::SAMPLE_BITS-1:0]    o_m_tdata
);
    import pktg_pkg::*;

    logic                   r_sounds;
    logic [PHASE_BITS-1:0]  r_phase;
    logic [PHASE_BITS-1:0]  r_step;
    logic [DIV_BITS-1:0]    r_div_q;
    logic [RATE_BITS-1:0]   r_rem;
    logic [ROM_BITS-1:0]    r_rom;
    logic                   r_neg;
    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_out;

    logic                   in_sounds;
    logic [FREQ_BITS-1:0]   freq_in;
    logic [RATE_BITS-1:0]   rate_eff;
    logic [RATE_BITS:0]     rem_shift;
    logic                   fits;
    logic [RATE_BITS:0]     rem_diff;
    logic [RATE_BITS-1:0]   n_rem;
    logic [DIV_BITS-1:0]    n_div_q;
    logic [IDX_BITS-1:0]    idx;
    logic [QTR_BITS-1:0]    qtr_j;
    logic [QTR_BITS-1:0]    qtr_addr;
    logic                   qtr_peak;
    logic [MAG_BITS-1:0]    mag;
    logic [MAG_BITS:0]      pos_sum;
    logic [MAG_BITS:0]      neg_mag;
    logic [MAG_BITS:0]      neg_diff;
    logic [SAMPLE_BITS-1:0] pos_val;
    logic [SAMPLE_BITS-1:0] neg_val;
    logic [SAMPLE_BITS-1:0] sample;

    assign in_sounds = (i_key != '0) && (i_key <= KEY_BITS'(KEY_COUNT));
    assign freq_in   = in_sounds ? FREQ_ROM[KEY_BITS'(i_key - 1'b1)] : '0;
    assign rate_eff  = (i_rate == '0) ? RATE_BITS'(1) : i_rate;

    assign rem_shift = {r_rem, r_div_q[DIV_BITS-1]};
    assign fits      = rem_shift >= {1'b0, rate_eff};
    assign rem_diff  = rem_shift - {1'b0, rate_eff};
    assign n_rem     = fits ? rem_diff[RATE_BITS-1:0] : rem_shift[RATE_BITS-1:0];
    assign n_div_q   = {r_div_q[DIV_BITS-2:0], fits};

    assign idx      = r_phase[PHASE_BITS-1 -: IDX_BITS];
    assign qtr_j    = idx[QTR_BITS-1:0];
    assign qtr_addr = idx[QTR_BITS] ? QTR_BITS'(~qtr_j + 1'b1) : qtr_j;
    assign qtr_peak = idx[QTR_BITS] && (qtr_j == '0);

    assign mag      = r_rom[ROM_BITS-1:1];
    assign pos_sum  = {1'b0, SAMPLE_MID} + {1'b0, mag};
    assign pos_val  = pos_sum[MAG_BITS] ? '1 : pos_sum[SAMPLE_BITS-1:0];
    assign neg_mag  = {1'b0, mag} + (MAG_BITS+1)'(r_rom[0]);
    assign neg_diff = {1'b0, SAMPLE_MID} - neg_mag;
    assign neg_val  = (neg_mag > {1'b0, SAMPLE_MID}) ? '0 : neg_diff[SAMPLE_BITS-1:0];
    assign sample   = !r_sounds ? SAMPLE_MID : (r_neg ? neg_val : pos_val);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load && i_note_start) begin
                r_phase <= '0;
            end else if (i_cmd.emit && r_sounds) begin
                r_phase <= r_phase + r_step;
            end
            if (i_cmd.step_clear) begin
                r_step <= '0;
            end else if (i_cmd.div_step && i_cmd.div_last) begin
                r_step <= n_div_q[PHASE_BITS-1:0];
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sounds <= in_sounds;
        end
        if (i_cmd.div_init) begin
            r_div_q <= DIV_BITS'(freq_in) << STEP_SHIFT;
            r_rem   <= '0;
        end else if (i_cmd.div_step) begin
            r_div_q <= n_div_q;
            r_rem   <= n_rem;
        end
        if (i_cmd.lookup) begin
            r_rom <= qtr_peak ? SINE_PEAK : SINE_ROM[qtr_addr];
            r_neg <= idx[IDX_BITS-1];
        end
        if (i_cmd.emit) begin
            r_out <= sample;
        end
    end

    assign o_status.in_sounds = in_sounds;
    assign o_status.out_stall = r_out_valid && !i_m_tready;
    assign o_m_tvalid         = r_out_valid;
    assign o_m_tdata          = r_out;

endmodule

`default_nettype wire

>>> design/piano_key_sine_tone_generator_unit.sv
// An accepted beat passes the lookup and output states on to the output register;
// on a note start of a sounding key the bit-serial step divider runs first.
// A beat is accepted only in the idle state, so a new beat waits until the last
// sample is emitted; a full output register waiting on i_m_tready holds the emit.
// Reset (synchronous, active low): phase and step clear to zero, sample_rate
// returns to 8000 and the output register empties. Tables are constant logic.
`default_nettype none

module piano_key_sine_tone_generator_unit (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_s_tvalid,
    output logic                                o_s_tready,
    input  wire  [7:0]                          i_s_tdata,  // [6:0] key, [7] zero
    input  wire                                 i_s_tuser,  // [0] note_start
    output logic                                o_m_tvalid,
    input  wire                                 i_m_tready,
    output logic [pktg_pkg::SAMPLE_BITS-1:0]    o_m_tdata,  // [7:0] sample
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire  [pktg_pkg::ADDR_BITS-1:0]      paddr,
    input  wire  [pktg_pkg::DATA_BITS-1:0]      pwdata,
    output logic [pktg_pkg::DATA_BITS-1:0]      prdata,
    output logic                                pready
);
    import pktg_pkg::*;

    logic [RATE_BITS-1:0] r_rate;
    t_cmd                 cmd;
    t_status              status;
    logic                 reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2] == REG_SAMPLE_RATE;
    assign prdata  = reg_sel ? DATA_BITS'(r_rate) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RATE_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_rate <= pwdata[RATE_BITS-1:0];
        end
    end

    pktg_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_note_start (i_s_tuser),
        .i_status     (status),
        .o_s_tready   (o_s_tready),
        .o_cmd        (cmd)
    );

    pktg_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_key        (i_s_tdata[KEY_BITS-1:0]),
        .i_note_start (i_s_tuser),
        .i_rate       (r_rate),
        .i_m_tready   (i_m_tready),
        .o_status     (status),
        .o_m_tvalid   (o_m_tvalid),
        .o_m_tdata    (o_m_tdata)
    );

endmodule

`default_nettype wire
